// ===== hdl/erj_pkg.sv =====
// Shared constants, types and helper functions of the Euler rotation block.
`default_nettype none
package erj_pkg;

  localparam int COORD_W      = 32;
  localparam int COEF_FRAC    = 16;
  localparam int COEF_W       = COEF_FRAC + 2;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_IT_W  = 5;
  localparam int CORDIC_W     = 33;
  localparam int CORDIC_ZW    = 34;
  localparam int NUM_COEF     = 36;
  localparam int NUM_OUT      = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

  localparam logic signed [COEF_W+1:0] COEF_HI = (COEF_W+2)'((1 << (COEF_W-1)) - 1);
  localparam logic signed [COEF_W+1:0] COEF_LO = (COEF_W+2)'(-(1 << (COEF_W-1)));

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    COEF_IDLE,
    COEF_ROT,
    COEF_TRIG,
    COEF_PROD,
    COEF_STORE
  } coef_state_e;

  typedef struct packed {
    logic                   load;
    logic                   step;
    logic                   finish;
    logic [CORDIC_IT_W-1:0] iter;
  } cordic_ctrl_t;

  // Arctangent of 2^-i, 2^32 per turn.
  function automatic logic signed [CORDIC_ZW-1:0] atan_turn(input logic [CORDIC_IT_W-1:0] i);
    logic signed [CORDIC_ZW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a widened coefficient into the Q1 range.
  function automatic coef_t sat_coef(input logic signed [COEF_W+1:0] v);
    coef_t r;
    if (v > COEF_HI) r = COEF_HI[COEF_W-1:0];
    else if (v < COEF_LO) r = COEF_LO[COEF_W-1:0];
    else r = v[COEF_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COEF_W+1:0] ext_coef(input coef_t v);
    return (COEF_W+2)'(v);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/erj_if.sv =====
// Point and result channel interfaces.
`default_nettype none
interface erj_point_if;
  logic            valid;
  logic            ready;
  erj_pkg::coord_t point_x;
  erj_pkg::coord_t point_y;
  erj_pkg::coord_t point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface erj_result_if;
  logic            valid;
  logic            ready;
  erj_pkg::coord_t rotated_x;
  erj_pkg::coord_t rotated_y;
  erj_pkg::coord_t rotated_z;
  erj_pkg::coord_t jac_row0_ax;
  erj_pkg::coord_t jac_row1_ax;
  erj_pkg::coord_t jac_row2_ax;
  erj_pkg::coord_t jac_row0_ay;
  erj_pkg::coord_t jac_row1_ay;
  erj_pkg::coord_t jac_row2_ay;
  erj_pkg::coord_t jac_row0_az;
  erj_pkg::coord_t jac_row1_az;
  erj_pkg::coord_t jac_row2_az;
  modport source(output valid, rotated_x, rotated_y, rotated_z,
                 jac_row0_ax, jac_row1_ax, jac_row2_ax,
                 jac_row0_ay, jac_row1_ay, jac_row2_ay,
                 jac_row0_az, jac_row1_az, jac_row2_az, input ready);
  modport sink(input valid, rotated_x, rotated_y, rotated_z,
               jac_row0_ax, jac_row1_ax, jac_row2_ax,
               jac_row0_ay, jac_row1_ay, jac_row2_ay,
               jac_row0_az, jac_row1_az, jac_row2_az, output ready);
endinterface
`default_nettype wire

// ===== hdl/erj_cordic.sv =====
// Iterative CORDIC: sine and cosine of one binary angle, one step per cycle.
`default_nettype none
module erj_cordic (
  input  wire                                 clk_i,
  input  wire erj_pkg::cordic_ctrl_t          ctrl_i,
  input  wire logic [erj_pkg::ANGLE_W-1:0]    angle_i,
  output erj_pkg::coef_t                      sin_o,
  output erj_pkg::coef_t                      cos_o
);

  localparam int SH = 30 - erj_pkg::COEF_FRAC;
  localparam logic signed [erj_pkg::CORDIC_W-1:0] HALF = erj_pkg::CORDIC_W'(1 << (SH - 1));
  localparam logic signed [erj_pkg::CORDIC_W-SH-1:0] ONE_P =
    (erj_pkg::CORDIC_W-SH)'(1 << erj_pkg::COEF_FRAC);
  localparam logic signed [erj_pkg::CORDIC_W-SH-1:0] ONE_N =
    (erj_pkg::CORDIC_W-SH)'(-(1 << erj_pkg::COEF_FRAC));

  logic signed [erj_pkg::CORDIC_W-1:0]  x_q, y_q, x_d, y_d, xs, ys, xf, yf, xr, yr;
  logic signed [erj_pkg::CORDIC_ZW-1:0] z_q, z_d, at;
  logic                                 flip_q, flip_d;
  logic [31:0]                          p, pf;
  logic signed [erj_pkg::CORDIC_W-SH-1:0] cq, sq;
  erj_pkg::coef_t                       sin_q, cos_q, sin_d, cos_d;

  always_comb begin
    p      = {angle_i, {(32 - erj_pkg::ANGLE_W){1'b0}}};
    flip_d = flip_q;
    pf     = p + 32'h4000_0000;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    xs     = x_q >>> ctrl_i.iter;
    ys     = y_q >>> ctrl_i.iter;
    at     = erj_pkg::atan_turn(ctrl_i.iter);
    if (ctrl_i.load) begin
      // turn angles outside the half circle by pi, negate at the end
      flip_d = pf[31];
      pf     = pf[31] ? p + 32'h8000_0000 : p;
      x_d    = erj_pkg::CORDIC_START;
      y_d    = '0;
      z_d    = erj_pkg::CORDIC_ZW'($signed(pf));
    end else if (ctrl_i.step) begin
      if (!z_q[erj_pkg::CORDIC_ZW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
    end
  end

  always_comb begin
    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
    xr = xf + HALF;
    yr = yf + HALF;
    cq = xr[erj_pkg::CORDIC_W-1:SH];
    sq = yr[erj_pkg::CORDIC_W-1:SH];
    if (cq > ONE_P) cos_d = ONE_P[erj_pkg::COEF_W-1:0];
    else if (cq < ONE_N) cos_d = ONE_N[erj_pkg::COEF_W-1:0];
    else cos_d = cq[erj_pkg::COEF_W-1:0];
    if (sq > ONE_P) sin_d = ONE_P[erj_pkg::COEF_W-1:0];
    else if (sq < ONE_N) sin_d = ONE_N[erj_pkg::COEF_W-1:0];
    else sin_d = sq[erj_pkg::COEF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    if (ctrl_i.finish) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

// ===== hdl/erj_coef.sv =====
// Angle registers, coefficient sequencer with one shared multiplier, coefficient store.
`default_nettype none
module erj_coef (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire logic [erj_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [erj_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output erj_pkg::coef_t                       coef_o [erj_pkg::NUM_COEF],
  output logic                                 busy_o
);

  localparam int NUM_PROD = 20;
  localparam int PROD_W   = 2 * erj_pkg::COEF_W;
  localparam logic [4:0] P_CZSY = 5'd0,  P_SZSY = 5'd1,  P_M0   = 5'd2,  P_A    = 5'd3;
  localparam logic [4:0] P_B    = 5'd4,  P_C    = 5'd5,  P_D    = 5'd6,  P_M3   = 5'd7;
  localparam logic [4:0] P_E    = 5'd8,  P_F    = 5'd9,  P_G    = 5'd10, P_H    = 5'd11;
  localparam logic [4:0] P_M7   = 5'd12, P_M8   = 5'd13, P_M19  = 5'd14, P_M20  = 5'd15;
  localparam logic [4:0] P_M22  = 5'd16, P_M23  = 5'd17, P_SYSX = 5'd18, P_SYCX = 5'd19;
  localparam logic [4:0] ROT_LAST  = 5'(erj_pkg::CORDIC_STEPS - 1);
  localparam logic [4:0] PROD_LAST = 5'(NUM_PROD - 1);
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1 << (erj_pkg::COEF_FRAC - 1));
  localparam erj_pkg::coef_t ONE = erj_pkg::COEF_W'(1 << erj_pkg::COEF_FRAC);

  logic [erj_pkg::ANGLE_W-1:0] ang_x_q, ang_y_q, ang_z_q;
  logic                        angle_wr;
  logic                        start_q;
  erj_pkg::coef_state_e        state_q, state_d;
  logic [4:0]                  cnt_q, cnt_d;
  erj_pkg::cordic_ctrl_t       cctl;
  logic                        store_en;
  erj_pkg::coef_t              sx, cx, sy, cy, sz, cz;
  erj_pkg::coef_t              op_a, op_b;
  erj_pkg::coef_t              p_q [NUM_PROD];
  logic signed [PROD_W-1:0]    mul, mul_r;
  erj_pkg::coef_t              m [erj_pkg::NUM_COEF];
  erj_pkg::coef_t              coef_q [erj_pkg::NUM_COEF];

  // Angle registers; any valid index restarts the recompute.
  assign angle_wr = cfg_we_i && (cfg_idx_i == erj_pkg::REG_ANGLE_X ||
                                 cfg_idx_i == erj_pkg::REG_ANGLE_Y ||
                                 cfg_idx_i == erj_pkg::REG_ANGLE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= angle_wr;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          erj_pkg::REG_ANGLE_X: ang_x_q <= cfg_data_i[erj_pkg::ANGLE_W-1:0];
          erj_pkg::REG_ANGLE_Y: ang_y_q <= cfg_data_i[erj_pkg::ANGLE_W-1:0];
          erj_pkg::REG_ANGLE_Z: ang_z_q <= cfg_data_i[erj_pkg::ANGLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (start_q) begin
      state_d = erj_pkg::COEF_ROT;
      cnt_d   = '0;
    end else begin
      unique case (state_q)
        erj_pkg::COEF_IDLE: ;
        erj_pkg::COEF_ROT: begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == ROT_LAST) begin
            state_d = erj_pkg::COEF_TRIG;
            cnt_d   = '0;
          end
        end
        erj_pkg::COEF_TRIG: state_d = erj_pkg::COEF_PROD;
        erj_pkg::COEF_PROD: begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == PROD_LAST) begin
            state_d = erj_pkg::COEF_STORE;
            cnt_d   = '0;
          end
        end
        erj_pkg::COEF_STORE: state_d = erj_pkg::COEF_IDLE;
        default: state_d = erj_pkg::COEF_IDLE;
      endcase
    end
  end

  // Outputs of the sequencer
  always_comb begin
    cctl.load   = start_q;
    cctl.step   = (state_q == erj_pkg::COEF_ROT) && !start_q;
    cctl.finish = (state_q == erj_pkg::COEF_TRIG);
    cctl.iter   = cnt_q;
    store_en    = (state_q == erj_pkg::COEF_STORE) && !start_q;
    busy_o      = start_q || (state_q != erj_pkg::COEF_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erj_pkg::COEF_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  erj_cordic u_cordic_x (.clk_i, .ctrl_i(cctl), .angle_i(ang_x_q), .sin_o(sx), .cos_o(cx));
  erj_cordic u_cordic_y (.clk_i, .ctrl_i(cctl), .angle_i(ang_y_q), .sin_o(sy), .cos_o(cy));
  erj_cordic u_cordic_z (.clk_i, .ctrl_i(cctl), .angle_i(ang_z_q), .sin_o(sz), .cos_o(cz));

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cnt_q)
      P_CZSY: begin op_a = cz;           op_b = sy; end
      P_SZSY: begin op_a = sz;           op_b = sy; end
      P_M0:   begin op_a = cz;           op_b = cy; end
      P_A:    begin op_a = p_q[P_CZSY];  op_b = sx; end
      P_B:    begin op_a = sz;           op_b = cx; end
      P_C:    begin op_a = p_q[P_CZSY];  op_b = cx; end
      P_D:    begin op_a = sz;           op_b = sx; end
      P_M3:   begin op_a = sz;           op_b = cy; end
      P_E:    begin op_a = p_q[P_SZSY];  op_b = sx; end
      P_F:    begin op_a = cz;           op_b = cx; end
      P_G:    begin op_a = p_q[P_SZSY];  op_b = cx; end
      P_H:    begin op_a = cz;           op_b = sx; end
      P_M7:   begin op_a = cy;           op_b = sx; end
      P_M8:   begin op_a = cy;           op_b = cx; end
      P_M19:  begin op_a = p_q[P_M0];    op_b = sx; end
      P_M20:  begin op_a = p_q[P_M0];    op_b = cx; end
      P_M22:  begin op_a = p_q[P_M3];    op_b = sx; end
      P_M23:  begin op_a = p_q[P_M3];    op_b = cx; end
      P_SYSX: begin op_a = sy;           op_b = sx; end
      P_SYCX: begin op_a = sy;           op_b = cx; end
      default: ;
    endcase
    mul   = op_a * op_b;
    mul_r = mul + PROD_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == erj_pkg::COEF_PROD && cnt_q <= PROD_LAST) begin
      p_q[cnt_q] <= mul_r[erj_pkg::COEF_FRAC +: erj_pkg::COEF_W];
    end
  end

  // Assemble the four matrices from the products
  always_comb begin
    m[0] = p_q[P_M0];
    m[1] = erj_pkg::sat_coef(erj_pkg::ext_coef(p_q[P_A]) - erj_pkg::ext_coef(p_q[P_B]));
    m[2] = erj_pkg::sat_coef(erj_pkg::ext_coef(p_q[P_C]) + erj_pkg::ext_coef(p_q[P_D]));
    m[3] = p_q[P_M3];
    m[4] = erj_pkg::sat_coef(erj_pkg::ext_coef(p_q[P_E]) + erj_pkg::ext_coef(p_q[P_F]));
    m[5] = erj_pkg::sat_coef(erj_pkg::ext_coef(p_q[P_G]) - erj_pkg::ext_coef(p_q[P_H]));
    m[6] = erj_pkg::sat_coef(-erj_pkg::ext_coef(sy));
    m[7] = p_q[P_M7];
    m[8] = p_q[P_M8];
    for (int r = 0; r < 3; r++) begin
      m[9 + 3*r]  = '0;
      m[10 + 3*r] = m[3*r + 2];
      m[11 + 3*r] = erj_pkg::sat_coef(-erj_pkg::ext_coef(m[3*r + 1]));
    end
    m[18] = erj_pkg::sat_coef(-erj_pkg::ext_coef(p_q[P_CZSY]));
    m[19] = p_q[P_M19];
    m[20] = p_q[P_M20];
    m[21] = erj_pkg::sat_coef(-erj_pkg::ext_coef(p_q[P_SZSY]));
    m[22] = p_q[P_M22];
    m[23] = p_q[P_M23];
    m[24] = erj_pkg::sat_coef(-erj_pkg::ext_coef(cy));
    m[25] = erj_pkg::sat_coef(-erj_pkg::ext_coef(p_q[P_SYSX]));
    m[26] = erj_pkg::sat_coef(-erj_pkg::ext_coef(p_q[P_SYCX]));
    for (int r = 0; r < 3; r++) begin
      m[27 + r] = erj_pkg::sat_coef(-erj_pkg::ext_coef(m[3 + r]));
      m[30 + r] = m[r];
      m[33 + r] = '0;
    end
  end

  // Store resets to identity rotation, zero derivatives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < erj_pkg::NUM_COEF; i++) begin
        coef_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
      end
    end else if (store_en) begin
      for (int i = 0; i < erj_pkg::NUM_COEF; i++) begin
        coef_q[i] <= m[i];
      end
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

// ===== hdl/erj_point.sv =====
// Four-stage point datapath: capture, products, row sums, round and saturate.
`default_nettype none
module erj_point (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire erj_pkg::coord_t   pt_i [3],
  input  wire erj_pkg::coef_t    coef_i [erj_pkg::NUM_COEF],
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output erj_pkg::coord_t        res_o [erj_pkg::NUM_OUT]
);

  localparam int PROD_W = erj_pkg::COEF_W + erj_pkg::COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - erj_pkg::COEF_FRAC;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< (erj_pkg::COEF_FRAC - 1));
  localparam logic signed [RND_W-1:0] C_MAX = RND_W'((64'sd1 <<< (erj_pkg::COORD_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] C_MIN = RND_W'(-(64'sd1 <<< (erj_pkg::COORD_W - 1)));

  logic                     en;
  logic                     v1_q, v2_q, v3_q, v4_q;
  erj_pkg::coord_t          pt_q [3];
  logic signed [PROD_W-1:0] prod_d [erj_pkg::NUM_OUT][3];
  logic signed [PROD_W-1:0] prod_q [erj_pkg::NUM_OUT][3];
  logic signed [SUM_W-1:0]  sum_d  [erj_pkg::NUM_OUT];
  logic signed [SUM_W-1:0]  sum_q  [erj_pkg::NUM_OUT];
  logic signed [SUM_W-1:0]  rnd    [erj_pkg::NUM_OUT];
  logic signed [RND_W-1:0]  shf    [erj_pkg::NUM_OUT];
  erj_pkg::coord_t          res_d  [erj_pkg::NUM_OUT];
  erj_pkg::coord_t          res_q  [erj_pkg::NUM_OUT];

  // Advance all stages together whenever the output slot frees up
  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    for (int n = 0; n < erj_pkg::NUM_OUT; n++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[n][k] = coef_i[3*n + k] * pt_q[k];
      end
      sum_d[n] = SUM_W'(prod_q[n][0]) + SUM_W'(prod_q[n][1]) + SUM_W'(prod_q[n][2]);
      rnd[n]   = sum_q[n] + HALF;
      shf[n]   = rnd[n][SUM_W-1:erj_pkg::COEF_FRAC];
      if (shf[n] > C_MAX) res_d[n] = C_MAX[erj_pkg::COORD_W-1:0];
      else if (shf[n] < C_MIN) res_d[n] = C_MIN[erj_pkg::COORD_W-1:0];
      else res_d[n] = shf[n][erj_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q   <= pt_i;
      prod_q <= prod_d;
      sum_q  <= sum_d;
      res_q  <= res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== hdl/euler_rotation_with_jacobian.sv =====
// Top level of the Euler ZYX rotation block with angle Jacobian.
`default_nettype none
// Rotates a stream of Q16.16 points by R = Rz*Ry*Rx and returns, with each
// rotated point, the three Jacobian columns dR/dangle * point, every result
// rounded half up and saturated to 32 bits. The point path takes one beat per
// cycle while not stalled or rebuilding and passes each result through the
// capture, 18x32 product, row sum and round-and-saturate registers; a stalled
// result beat holds the whole pipeline without losing or repeating anything.
// Writing an angle register (index 0, 1 or 2; index 3 is ignored) recomputes
// the 36 coefficients: three CORDIC units run 30 steps in parallel, then one
// shared 18x18 multiplier forms 20 products, one per cycle, so the point
// channel stays not ready until the new coefficients are stored. Write angles
// only while no point is in flight. After reset the coefficients are identity
// rotation and zero derivatives until the first angle write.
module euler_rotation_with_jacobian (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire logic [erj_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [erj_pkg::CFG_DATA_W-1:0] cfg_data_i,
  erj_point_if.sink                           point_i,
  erj_result_if.source                        result_o
);

  logic            busy;
  logic            pt_ready;
  erj_pkg::coef_t  coef [erj_pkg::NUM_COEF];
  erj_pkg::coord_t pt [3];
  erj_pkg::coord_t res [erj_pkg::NUM_OUT];

  // Coefficient side: angle registers, CORDIC, sequencer, store
  erj_coef u_coef (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .coef_o (coef),
    .busy_o (busy)
  );

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  // Hold off point beats while the coefficients are being rebuilt
  assign point_i.ready = pt_ready && !busy;

  erj_point u_point (
    .clk_i,
    .rst_ni,
    .in_valid_i  (point_i.valid && !busy),
    .in_ready_o  (pt_ready),
    .pt_i        (pt),
    .coef_i      (coef),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.rotated_x   = res[0];
  assign result_o.rotated_y   = res[1];
  assign result_o.rotated_z   = res[2];
  assign result_o.jac_row0_ax = res[3];
  assign result_o.jac_row1_ax = res[4];
  assign result_o.jac_row2_ax = res[5];
  assign result_o.jac_row0_ay = res[6];
  assign result_o.jac_row1_ay = res[7];
  assign result_o.jac_row2_ay = res[8];
  assign result_o.jac_row0_az = res[9];
  assign result_o.jac_row1_az = res[10];
  assign result_o.jac_row2_az = res[11];

  // No point beat is taken while the coefficients change
  a_no_beat_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !point_i.ready)
    else $error("point beat accepted during coefficient rebuild");

  // An angle write starts a rebuild
  a_write_starts_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == erj_pkg::REG_ANGLE_X || cfg_idx_i == erj_pkg::REG_ANGLE_Y ||
                  cfg_idx_i == erj_pkg::REG_ANGLE_Z)) |=> busy)
    else $error("angle write did not start a rebuild");

  // A rebuild only ever begins from an angle write
  a_busy_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(cfg_we_i))
    else $error("rebuild started without an angle write");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the Euler ZYX rotation block with angle Jacobian.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import erj_pkg::*;

  // Index 3 of the register space is decoded as nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;

  typedef struct {
    coord_t f[NUM_OUT];
  } result_beat_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Arctangent of 2^-i at 2^32 per turn, for the predictor's CORDIC.
  localparam longint ATAN_TBL[CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  string field_names[NUM_OUT] = '{
    "rotated_x", "rotated_y", "rotated_z",
    "jac_row0_ax", "jac_row1_ax", "jac_row2_ax",
    "jac_row0_ay", "jac_row1_ay", "jac_row2_ay",
    "jac_row0_az", "jac_row1_az", "jac_row2_az"};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  erj_point_if  pt ();
  erj_result_if res ();

  euler_rotation_with_jacobian dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (pt.sink),
    .result_o  (res.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: angle registers and the 36 Q1.16 coefficients
  // (R, dR/dx, dR/dy, dR/dz, each row-major).
  logic [ANGLE_W-1:0] angle_regs[3];
  longint             coefs[NUM_COEF];

  point_t       pending_points[$];
  result_beat_t expected_results[$];
  int           fail_count = 0;
  bit           gaps_off = 1'b0;
  bit           long_hold_req = 1'b0;
  bit           long_hold_done = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Product of two Q1.16 values, rounded half up.
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  // CORDIC sine and cosine of a binary angle; turn by pi outside [-pi/2, pi/2).
  function automatic void trig_of(input logic [ANGLE_W-1:0] a,
                                  output longint s, output longint c);
    bit [31:0] p;
    bit [31:0] probe;
    bit        flip;
    longint    x, y, z, nx;
    longint    one;
    p     = {a, {(32 - ANGLE_W){1'b0}}};
    probe = p + 32'h4000_0000;
    flip  = probe >= 32'h8000_0000;
    one   = 64'sd1 <<< COEF_FRAC;
    if (flip) p = p + 32'h8000_0000;
    z = longint'($signed(p));
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TBL[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip((x + (64'sd1 <<< (29 - COEF_FRAC))) >>> (30 - COEF_FRAC), -one, one);
    s = clip((y + (64'sd1 <<< (29 - COEF_FRAC))) >>> (30 - COEF_FRAC), -one, one);
  endfunction

  // Rebuild rotation and derivative coefficients from the three angles.
  function automatic void rebuild_coefs();
    longint sx, cx, sy, cy, sz, cz, czsy, szsy, lim;
    longint m[NUM_COEF];
    lim = 64'sd1 <<< (COEF_FRAC + 1);
    trig_of(angle_regs[0], sx, cx);
    trig_of(angle_regs[1], sy, cy);
    trig_of(angle_regs[2], sz, cz);
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    m[0] = qmul(cz, cy);
    m[1] = qmul(czsy, sx) - qmul(sz, cx);
    m[2] = qmul(czsy, cx) + qmul(sz, sx);
    m[3] = qmul(sz, cy);
    m[4] = qmul(szsy, sx) + qmul(cz, cx);
    m[5] = qmul(szsy, cx) - qmul(cz, sx);
    m[6] = -sy;
    m[7] = qmul(cy, sx);
    m[8] = qmul(cy, cx);
    for (int r = 0; r < 9; r++) m[r] = clip(m[r], -lim, lim - 1);
    for (int r = 0; r < 3; r++) begin
      m[9 + r*3]     = 0;
      m[9 + r*3 + 1] = m[r*3 + 2];
      m[9 + r*3 + 2] = -m[r*3 + 1];
    end
    m[18] = -czsy; m[19] = qmul(m[0], sx);  m[20] = qmul(m[0], cx);
    m[21] = -szsy; m[22] = qmul(m[3], sx);  m[23] = qmul(m[3], cx);
    m[24] = -cy;   m[25] = -qmul(sy, sx);   m[26] = -qmul(sy, cx);
    for (int r = 0; r < 3; r++) begin
      m[27 + r] = -m[3 + r];
      m[30 + r] = m[r];
      m[33 + r] = 0;
    end
    for (int r = 0; r < NUM_COEF; r++) coefs[r] = clip(m[r], -lim, lim - 1);
  endfunction

  // Rotated point and Jacobian columns for one point, with exact row sums.
  function automatic result_beat_t rotate_point(point_t p);
    result_beat_t rb;
    longint v[3], hi[3], lo[3];
    longint sh, sl, acc, top;
    int     base;
    top  = (64'sd1 <<< (COORD_W - 1)) - 1;
    v[0] = p.x; v[1] = p.y; v[2] = p.z;
    for (int k = 0; k < 3; k++) begin
      hi[k] = v[k] >>> COEF_FRAC;
      lo[k] = v[k] - (hi[k] <<< COEF_FRAC);
    end
    for (int o = 0; o < NUM_OUT; o++) begin
      // Outputs 0..2 use R; the rest walk dR/dx, dR/dy, dR/dz row by row.
      base = (o < 3) ? o * 3 : 9 * ((o - 3) / 3 + 1) + ((o - 3) % 3) * 3;
      sh = 0; sl = 0;
      for (int k = 0; k < 3; k++) begin
        sh += coefs[base + k] * hi[k];
        sl += coefs[base + k] * lo[k];
      end
      acc = sh + ((sl + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
      rb.f[o] = coord_t'(clip(acc, -top - 1, top));
    end
    return rb;
  endfunction

  // Driver: present queued points, with a random gap drawn after each point.
  int point_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    point_t nxt;
    if (!rst_ni) begin
      pt.valid   <= 1'b0;
      pt.point_x <= '0;
      pt.point_y <= '0;
      pt.point_z <= '0;
      point_gap  <= 0;
    end else begin
      if (pt.valid && pt.ready) begin
        nxt.x = pt.point_x; nxt.y = pt.point_y; nxt.z = pt.point_z;
        expected_results.push_back(rotate_point(nxt));
      end
      // Hold the beat while it is stalled; otherwise advance.
      if (!pt.valid || pt.ready) begin
        if (point_gap > 0) begin
          point_gap <= point_gap - 1;
          pt.valid  <= 1'b0;
        end else if (pending_points.size() > 0) begin
          nxt = pending_points.pop_front();
          pt.point_x <= nxt.x;
          pt.point_y <= nxt.y;
          pt.point_z <= nxt.z;
          pt.valid   <= 1'b1;
          point_gap  <= gaps_off ? 0 : $urandom_range(0, 4);
        end else begin
          pt.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction and
  // throttle ready, with one long hold-off to back up the pipeline.
  int result_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    result_beat_t got, want;
    int           hold_next;
    if (!rst_ni) begin
      res.ready   <= 1'b0;
      result_hold <= 0;
    end else begin
      hold_next = (result_hold > 0) ? result_hold - 1 : 0;
      if (res.valid && res.ready) begin
        got.f = '{res.rotated_x, res.rotated_y, res.rotated_z,
                  res.jac_row0_ax, res.jac_row1_ax, res.jac_row2_ax,
                  res.jac_row0_ay, res.jac_row1_ay, res.jac_row2_ay,
                  res.jac_row0_az, res.jac_row1_az, res.jac_row2_az};
        if (expected_results.size() == 0) begin
          $error("result beat with no point outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          for (int o = 0; o < NUM_OUT; o++)
            if (got.f[o] !== want.f[o]) begin
              $error("%s: expected %0d, got %0d", field_names[o], want.f[o], got.f[o]);
              fail_count++;
            end
        end
        hold_next = gaps_off ? 0 : $urandom_range(0, 4);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_next      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      result_hold <= hold_next;
      res.ready   <= (hold_next == 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void add_point(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
      2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 9)
                                           : 32'sh8000_0000 + $urandom_range(0, 9);
      default: return coord_t'($signed($urandom) >>> $urandom_range(0, 31));
    endcase
  endfunction

  // Drain: wait until every point is sent and every result is back.
  task automatic drain();
    while (pending_points.size() > 0 || pt.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one angle register while idle, then wait for the rebuild to finish.
  task automatic write_angle(logic [CFG_IDX_W-1:0] idx, logic [ANGLE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != REG_UNUSED) begin
      angle_regs[idx] = val;
      rebuild_coefs();
    end
    repeat (2) @(posedge clk_i);
    while (!pt.ready) @(posedge clk_i);
  endtask

  task automatic random_points(int count);
    repeat (count) add_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    logic [ANGLE_W-1:0] a;
    angle_regs = '{default: '0};
    coefs      = '{default: 0};
    coefs[0]   = 64'sd1 <<< COEF_FRAC;
    coefs[4]   = 64'sd1 <<< COEF_FRAC;
    coefs[8]   = 64'sd1 <<< COEF_FRAC;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Before any angle write: identity rotation and zero Jacobian.
    add_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    add_point(-32'sd1, 32'sd1, 32'sh0000_8000);
    drain();

    // Index 3 is ignored; then an explicit zero still rebuilds the store.
    write_angle(REG_UNUSED, 16'h1234);
    add_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    drain();
    write_angle(REG_ANGLE_X, 16'h0000);
    add_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    drain();

    // 45 degrees about z saturates a full-scale diagonal point.
    write_angle(REG_ANGLE_Z, 16'h2000);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000);
    add_point(32'sh0000_FFFF, -32'sh0000_8000, 32'sh0000_8000);
    drain();

    // Angle extremes and the quarter-turn fold boundaries.
    write_angle(REG_ANGLE_X, 16'h8000);
    write_angle(REG_ANGLE_Y, 16'h7FFF);
    write_angle(REG_ANGLE_Z, 16'hC000);
    add_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    add_point(32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh8000_0000);
    add_point(32'sh0000_0001, -32'sh0000_0001, 32'sh7FFF_0000);
    drain();
    write_angle(REG_ANGLE_X, 16'h4000);
    write_angle(REG_ANGLE_Y, 16'hBFFF);
    write_angle(REG_ANGLE_Z, 16'h3FFF);
    add_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0004_0000);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // Random phases over several angle settings; bursts with no idling too.
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 3; r++)
        if (ph < 2 || $urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 3))
            0:       a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1:       a = 16'(($urandom_range(0, 7)) * 16'h2000);
            default: a = 16'($urandom);
          endcase
          write_angle(r[CFG_IDX_W-1:0], a);
        end
      if (ph == 4) write_angle(REG_UNUSED, 16'($urandom));
      gaps_off = (ph % 3 == 2);
      if (ph == 5) begin
        // Back up the pipeline: results held off while points keep coming.
        gaps_off = 1'b1;
        repeat (60) add_point(rand_coord(), rand_coord(), rand_coord());
        long_hold_req = 1'b1;
      end
      random_points(65);
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
